// ===== design/fio_pkg.sv =====
// ============================================================================
// fio_pkg
// Shared constants and helpers for the Fresnel interface optics pipeline.
// ============================================================================
package fio_pkg;

    // Fixed-point formats.
    localparam int VEC_FRAC_BITS   = 14;
    localparam int INDEX_FRAC_BITS = 12;
    localparam int VEC_HALF        = 1 << (VEC_FRAC_BITS - 1);
    localparam int IDX_HALF        = 1 << (INDEX_FRAC_BITS - 1);
    localparam int COS_ONE         = 1 << VEC_FRAC_BITS;
    localparam int COEF_BITS       = 16;
    localparam int RATIO_CAP       = 4 << INDEX_FRAC_BITS;
    localparam int COEF_CAP        = 4 << COEF_BITS;
    localparam int PROB_ONE        = 32768;
    localparam int PROB_SHIFT      = 18;

    // Pipelined restoring divider geometry.
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_QUO_W = 19;

    // Pipelined square root geometry.
    localparam int SQ_IN_W  = 29;
    localparam int SQ_OUT_W = 15;

    // Valid bits up to the stage in front of the output register.
    localparam int PIPE_DEPTH = 64;

    // Saturate a signed value to the 16-bit field range.
    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        logic [15:0] res;
        if (v > 24'sd32767) begin
            res = 16'h7fff;
        end else if (v < -24'sd32768) begin
            res = 16'h8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

// ===== design/fio_if.sv =====
// ============================================================================
// fio_if
// Valid/ready channels for ray hit words and optics result words.
// ============================================================================
interface fio_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] inc_x;
    logic [15:0] inc_y;
    logic [15:0] inc_z;
    logic [15:0] nrm_x;
    logic [15:0] nrm_y;
    logic [15:0] nrm_z;
    logic [14:0] index_from;
    logic [14:0] index_to;

    modport source (output valid, inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z,
                    index_from, index_to, input ready);
    modport sink   (input valid, inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z,
                    index_from, index_to, output ready);
endinterface

interface fio_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] reflect_prob;
    logic        total_internal;
    logic [15:0] refl_x;
    logic [15:0] refl_y;
    logic [15:0] refl_z;
    logic [15:0] refr_x;
    logic [15:0] refr_y;
    logic [15:0] refr_z;

    modport source (output valid, reflect_prob, total_internal, refl_x, refl_y, refl_z,
                    refr_x, refr_y, refr_z, input ready);
    modport sink   (input valid, reflect_prob, total_internal, refl_x, refl_y, refl_z,
                    refr_x, refr_y, refr_z, output ready);
endinterface

// ===== design/fresnel_interface_optics_top.sv =====
// ============================================================================
// fresnel_interface_optics_top
// Fresnel reflectance, mirror and Snell directions for one ray hit per word.
// ============================================================================
// Throughput: one word per cycle; the index ratio divider, the cosT square
// root and the two coefficient dividers are fully pipelined, one bit a stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module fresnel_interface_optics_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fio_in_if.sink    i_in,
    fio_out_if.source o_out
);
    import fio_pkg::*;

    typedef struct packed {
        logic [2:0][15:0] ii;
        logic [2:0][15:0] nn;
        logic [14:0]      nf;
        logic [14:0]      nt;
        logic [15:0]      cosi;
        logic [14:0]      s;
        logic [2:0][15:0] refl;
    } t_w1;

    typedef struct packed {
        logic [2:0][15:0] nn;
        logic [14:0]      nf;
        logic [14:0]      nt;
        logic [15:0]      cosi;
        logic [2:0][15:0] refl;
        logic [17:0]      rcos;
        logic [2:0][19:0] iir;
        logic             tir;
    } t_w2;

    typedef struct packed {
        logic [2:0][15:0] nn;
        logic [2:0][15:0] refl;
        logic [2:0][19:0] iir;
        logic             tir;
    } t_w3;

    typedef struct packed {
        logic [2:0][15:0] refl;
        logic [2:0][15:0] refr;
        logic             tir;
        logic             zero;
    } t_w4;

    logic en;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic r_out_valid;

    // The pipeline advances whenever the output slot is free or being taken.
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
            r_out_valid <= r_vld[PIPE_DEPTH-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: dot product terms and the index ratio dividend.
    // ------------------------------------------------------------------
    logic [2:0][15:0] in_ii, in_nn;
    logic [14:0]      in_den;
    logic [2:0][31:0] n_s1_p;

    assign in_ii  = {i_in.inc_z, i_in.inc_y, i_in.inc_x};
    assign in_nn  = {i_in.nrm_z, i_in.nrm_y, i_in.nrm_x};
    assign in_den = (i_in.index_to == 15'd0) ? 15'd1 : i_in.index_to;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s1_p[k] = 32'($signed(in_nn[k])) * 32'($signed(in_ii[k]));
        end
    end

    logic [2:0][15:0]     r_s1_ii, r_s1_nn;
    logic [14:0]          r_s1_nf, r_s1_nt;
    logic [2:0][31:0]     r_s1_p;
    logic [DIV_NUM_W-1:0] r_s1_rnum;
    logic [DIV_DEN_W-1:0] r_s1_rden;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ii   <= in_ii;
            r_s1_nn   <= in_nn;
            r_s1_nf   <= i_in.index_from;
            r_s1_nt   <= i_in.index_to;
            r_s1_p    <= n_s1_p;
            r_s1_rnum <= (DIV_NUM_W'(i_in.index_from) << INDEX_FRAC_BITS)
                       + DIV_NUM_W'(in_den >> 1);
            r_s1_rden <= DIV_DEN_W'(in_den);
        end
    end

    // Index ratio divider, result aligned with the first delay line's end.
    logic [DIV_QUO_W-1:0] ra_quo;
    logic                 ra_ovf;

    fio_udiv u_div_ratio (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s1_rnum),
        .i_den (r_s1_rden),
        .o_quo (ra_quo),
        .o_ovf (ra_ovf)
    );

    // ------------------------------------------------------------------
    // Stage 2: cosI, rounded and clamped to [-1, 1].
    // ------------------------------------------------------------------
    logic signed [33:0] n_dot;
    logic signed [34:0] n_nd;
    logic signed [34:0] n_ci;
    logic [15:0]        n_cosi;

    assign n_dot = 34'($signed(r_s1_p[0])) + 34'($signed(r_s1_p[1]))
                 + 34'($signed(r_s1_p[2]));
    assign n_nd  = 35'sd0 - 35'(n_dot) + 35'(VEC_HALF);
    assign n_ci  = n_nd >>> VEC_FRAC_BITS;

    always_comb begin
        if (n_ci > 35'(COS_ONE)) begin
            n_cosi = 16'(COS_ONE);
        end else if (n_ci < -35'(COS_ONE)) begin
            n_cosi = 16'(-COS_ONE);
        end else begin
            n_cosi = n_ci[15:0];
        end
    end

    logic [2:0][15:0] r_s2_ii, r_s2_nn;
    logic [14:0]      r_s2_nf, r_s2_nt;
    logic [15:0]      r_s2_cosi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ii   <= r_s1_ii;
            r_s2_nn   <= r_s1_nn;
            r_s2_nf   <= r_s1_nf;
            r_s2_nt   <= r_s1_nt;
            r_s2_cosi <= n_cosi;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cosI squared and the mirror products n * cosI.
    // ------------------------------------------------------------------
    logic signed [31:0] n_csq;
    logic [2:0][31:0]   n_ncos;

    assign n_csq = 32'($signed(r_s2_cosi)) * 32'($signed(r_s2_cosi));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ncos[k] = 32'($signed(r_s2_nn[k])) * 32'($signed(r_s2_cosi));
        end
    end

    logic [2:0][15:0] r_s3_ii, r_s3_nn;
    logic [14:0]      r_s3_nf, r_s3_nt;
    logic [15:0]      r_s3_cosi;
    logic [28:0]      r_s3_csq;
    logic [2:0][31:0] r_s3_ncos;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ii   <= r_s2_ii;
            r_s3_nn   <= r_s2_nn;
            r_s3_nf   <= r_s2_nf;
            r_s3_nt   <= r_s2_nt;
            r_s3_cosi <= r_s2_cosi;
            r_s3_csq  <= n_csq[28:0];
            r_s3_ncos <= n_ncos;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: 1 - cosI^2 and the reflected direction.
    // ------------------------------------------------------------------
    logic [29:0]      n_sv;
    t_w1              n_s4;

    assign n_sv = (30'(1) << (2 * VEC_FRAC_BITS)) - 30'(r_s3_csq) + 30'(VEC_HALF);

    always_comb begin
        logic signed [33:0] t;
        logic signed [19:0] u;
        logic signed [19:0] v;
        n_s4.ii   = r_s3_ii;
        n_s4.nn   = r_s3_nn;
        n_s4.nf   = r_s3_nf;
        n_s4.nt   = r_s3_nt;
        n_s4.cosi = r_s3_cosi;
        n_s4.s    = n_sv[VEC_FRAC_BITS +: 15];
        for (int k = 0; k < 3; k++) begin
            t = (34'($signed(r_s3_ncos[k])) <<< 1) + 34'(VEC_HALF);
            u = 20'(t >>> VEC_FRAC_BITS);
            v = u + 20'($signed(r_s3_ii[k]));
            n_s4.refl[k] = sat16(24'(v));
        end
    end

    t_w1 r_s4;
    t_w1 r_d1 [DIV_QUO_W - 3];

    // Hold the ray data while the ratio divider works.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4    <= n_s4;
            r_d1[0] <= r_s4;
            for (int k = 1; k < DIV_QUO_W - 3; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Ratio capped at 4.0, then r^2, r * cosI and i * r.
    // ------------------------------------------------------------------
    t_w1         r_s21_w;
    logic [14:0] r_s21_r;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s21_w <= r_d1[DIV_QUO_W - 4];
            if (ra_ovf || ra_quo > DIV_QUO_W'(RATIO_CAP)) begin
                r_s21_r <= 15'(RATIO_CAP);
            end else begin
                r_s21_r <= ra_quo[14:0];
            end
        end
    end

    logic [2:0][31:0] n_iir;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_iir[k] = 32'($signed(r_s21_w.ii[k])) * 32'($signed({1'b0, r_s21_r}));
        end
    end

    t_w1              r_s22_w;
    logic [28:0]      r_s22_rr;
    logic [31:0]      r_s22_rcos;
    logic [2:0][31:0] r_s22_iir;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s22_w    <= r_s21_w;
            r_s22_rr   <= 29'(r_s21_r) * 29'(r_s21_r);
            r_s22_rcos <= 32'($signed({1'b0, r_s21_r})) * 32'($signed(r_s21_w.cosi));
            r_s22_iir  <= n_iir;
        end
    end

    // Round the ratio products.
    logic [29:0]        n_r2w;
    logic signed [31:0] n_rcw;
    t_w2                n_s23;

    assign n_r2w = 30'(r_s22_rr) + 30'(IDX_HALF);
    assign n_rcw = ($signed(r_s22_rcos) + 32'sd2048) >>> INDEX_FRAC_BITS;

    always_comb begin
        logic signed [31:0] t;
        n_s23.nn   = r_s22_w.nn;
        n_s23.nf   = r_s22_w.nf;
        n_s23.nt   = r_s22_w.nt;
        n_s23.cosi = r_s22_w.cosi;
        n_s23.refl = r_s22_w.refl;
        n_s23.rcos = n_rcw[17:0];
        n_s23.tir  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            t = ($signed(r_s22_iir[k]) + 32'(IDX_HALF)) >>> INDEX_FRAC_BITS;
            n_s23.iir[k] = t[19:0];
        end
    end

    t_w2         r_s23_w;
    logic [14:0] r_s23_s;
    logic [16:0] r_s23_r2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s23_w  <= n_s23;
            r_s23_s  <= r_s22_w.s;
            r_s23_r2 <= n_r2w[INDEX_FRAC_BITS +: 17];
        end
    end

    // sinT^2 = r^2 (1 - cosI^2).
    t_w2         r_s24_w;
    logic [30:0] r_s24_r2s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s24_w   <= r_s23_w;
            r_s24_r2s <= 31'(r_s23_r2) * 31'(r_s23_s);
        end
    end

    // Total internal reflection test and the square root operand.
    logic [31:0] n_sinw;
    logic [18:0] n_sin;
    logic        n_tir;
    logic [18:0] n_cdiff;
    t_w2         n_s25;

    assign n_sinw  = 32'(r_s24_r2s) + 32'(IDX_HALF);
    assign n_sin   = n_sinw[INDEX_FRAC_BITS +: 19];
    assign n_tir   = n_sin > 19'(COS_ONE);
    assign n_cdiff = 19'(COS_ONE) - n_sin;

    // The ray word picks up its total reflection flag here.
    always_comb begin
        n_s25     = r_s24_w;
        n_s25.tir = n_tir;
    end

    t_w2                r_s25_w;
    logic [SQ_IN_W-1:0] r_s25_sqx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s25_w   <= n_s25;
            r_s25_sqx <= n_tir ? '0 : {n_cdiff[14:0], {VEC_FRAC_BITS{1'b0}}};
        end
    end

    logic [SQ_OUT_W-1:0] sq_root;

    fio_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (r_s25_sqx),
        .o_root (sq_root)
    );

    t_w2 r_d2 [SQ_OUT_W];

    // Hold the ray data while the square root works.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2[0] <= r_s25_w;
            for (int k = 1; k < SQ_OUT_W; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Fresnel terms a, b, c, d and the refraction weight m.
    // ------------------------------------------------------------------
    t_w2 n_q;
    t_w3 n_s41;

    assign n_q = r_d2[SQ_OUT_W-1];

    always_comb begin
        n_s41.nn   = n_q.nn;
        n_s41.refl = n_q.refl;
        n_s41.iir  = n_q.iir;
        n_s41.tir  = n_q.tir;
    end

    t_w3         r_s41_w;
    logic [31:0] r_s41_a, r_s41_c;
    logic [29:0] r_s41_b, r_s41_d;
    logic [18:0] r_s41_m;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s41_w <= n_s41;
            r_s41_a <= 32'($signed({1'b0, n_q.nf})) * 32'($signed(n_q.cosi));
            r_s41_b <= 30'(n_q.nt) * 30'(sq_root);
            r_s41_c <= 32'($signed({1'b0, n_q.nt})) * 32'($signed(n_q.cosi));
            r_s41_d <= 30'(n_q.nf) * 30'(sq_root);
            r_s41_m <= 19'($signed(n_q.rcos)) - 19'(sq_root);
        end
    end

    // Sums and differences of the terms, and n * m.
    logic [2:0][34:0] n_nnm;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_nnm[k] = 35'($signed(r_s41_w.nn[k])) * 35'($signed(r_s41_m));
        end
    end

    t_w3              r_s42_w;
    logic [32:0]      r_s42_abp, r_s42_abm, r_s42_cdp, r_s42_cdm;
    logic [2:0][34:0] r_s42_nnm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s42_w   <= r_s41_w;
            r_s42_abp <= 33'($signed(r_s41_a)) + 33'(r_s41_b);
            r_s42_abm <= 33'($signed(r_s41_a)) - 33'(r_s41_b);
            r_s42_cdp <= 33'($signed(r_s41_c)) + 33'(r_s41_d);
            r_s42_cdm <= 33'($signed(r_s41_c)) - 33'(r_s41_d);
            r_s42_nnm <= n_nnm;
        end
    end

    // Divider operands, the zero denominator case and the refracted direction.
    logic [32:0] n_mabp, n_mabm, n_mcdp, n_mcdm;
    t_w4         n_s43;

    assign n_mabp = r_s42_abp[32] ? 33'd0 - r_s42_abp : r_s42_abp;
    assign n_mabm = r_s42_abm[32] ? 33'd0 - r_s42_abm : r_s42_abm;
    assign n_mcdp = r_s42_cdp[32] ? 33'd0 - r_s42_cdp : r_s42_cdp;
    assign n_mcdm = r_s42_cdm[32] ? 33'd0 - r_s42_cdm : r_s42_cdm;

    always_comb begin
        logic signed [34:0] t;
        logic signed [21:0] v;
        n_s43.refl = r_s42_w.refl;
        n_s43.tir  = r_s42_w.tir;
        n_s43.zero = (r_s42_abp == 33'd0) || (r_s42_cdp == 33'd0);
        for (int k = 0; k < 3; k++) begin
            t = ($signed(r_s42_nnm[k]) + 35'(VEC_HALF)) >>> VEC_FRAC_BITS;
            v = 22'(t) + 22'($signed(r_s42_w.iir[k]));
            n_s43.refr[k] = r_s42_w.tir ? 16'd0 : sat16(24'(v));
        end
    end

    t_w4                  r_s43_w;
    logic [DIV_NUM_W-1:0] r_s43_numo, r_s43_nump;
    logic [DIV_DEN_W-1:0] r_s43_deno, r_s43_denp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s43_w    <= n_s43;
            r_s43_numo <= (DIV_NUM_W'(n_mabm) << COEF_BITS) + DIV_NUM_W'(n_mabp >> 1);
            r_s43_deno <= n_mabp;
            r_s43_nump <= (DIV_NUM_W'(n_mcdm) << COEF_BITS) + DIV_NUM_W'(n_mcdp >> 1);
            r_s43_denp <= n_mcdp;
        end
    end

    // Orthogonal and parallel coefficient dividers.
    logic [DIV_QUO_W-1:0] qo_quo, qp_quo;
    logic                 qo_ovf, qp_ovf;

    fio_udiv u_div_orth (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s43_numo),
        .i_den (r_s43_deno),
        .o_quo (qo_quo),
        .o_ovf (qo_ovf)
    );

    fio_udiv u_div_para (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s43_nump),
        .i_den (r_s43_denp),
        .o_quo (qp_quo),
        .o_ovf (qp_ovf)
    );

    t_w4 r_d3 [DIV_QUO_W];

    // Hold the directions while the coefficient dividers work.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3[0] <= r_s43_w;
            for (int k = 1; k < DIV_QUO_W; k++) begin
                r_d3[k] <= r_d3[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficients capped at 4.0, squared, summed and rounded to Q1.15.
    // ------------------------------------------------------------------
    t_w4                  r_s63_w;
    logic [DIV_QUO_W-1:0] r_s63_qo, r_s63_qp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s63_w  <= r_d3[DIV_QUO_W-1];
            r_s63_qo <= (qo_ovf || qo_quo > DIV_QUO_W'(COEF_CAP)) ?
                        DIV_QUO_W'(COEF_CAP) : qo_quo;
            r_s63_qp <= (qp_ovf || qp_quo > DIV_QUO_W'(COEF_CAP)) ?
                        DIV_QUO_W'(COEF_CAP) : qp_quo;
        end
    end

    t_w4         r_s64_w;
    logic [36:0] r_s64_sqo, r_s64_sqp;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s64_w   <= r_s63_w;
            r_s64_sqo <= 37'(r_s63_qo) * 37'(r_s63_qo);
            r_s64_sqp <= 37'(r_s63_qp) * 37'(r_s63_qp);
        end
    end

    logic [37:0] n_sum;
    logic [19:0] n_pr;
    logic [15:0] n_prob;

    assign n_sum = 38'(r_s64_sqo) + 38'(r_s64_sqp) + 38'(1 << (PROB_SHIFT - 1));
    assign n_pr  = n_sum[PROB_SHIFT +: 20];

    always_comb begin
        if (r_s64_w.tir || r_s64_w.zero || n_pr > 20'(PROB_ONE)) begin
            n_prob = 16'(PROB_ONE);
        end else begin
            n_prob = n_pr[15:0];
        end
    end

    // Output register.
    logic [15:0]      r_out_prob;
    logic             r_out_tir;
    logic [2:0][15:0] r_out_refl, r_out_refr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_prob <= n_prob;
            r_out_tir  <= r_s64_w.tir;
            r_out_refl <= r_s64_w.refl;
            r_out_refr <= r_s64_w.refr;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.reflect_prob   = r_out_prob;
    assign o_out.total_internal = r_out_tir;
    assign o_out.refl_x         = r_out_refl[0];
    assign o_out.refl_y         = r_out_refl[1];
    assign o_out.refl_z         = r_out_refl[2];
    assign o_out.refr_x         = r_out_refr[0];
    assign o_out.refr_y         = r_out_refr[1];
    assign o_out.refr_z         = r_out_refr[2];

endmodule

// ===== design/fio_udiv.sv =====
// ============================================================================
// fio_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ============================================================================
module fio_udiv (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [fio_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [fio_pkg::DIV_DEN_W-1:0] i_den,
    output logic [fio_pkg::DIV_QUO_W-1:0] o_quo,
    output logic                          o_ovf
);
    import fio_pkg::*;

    localparam int CMP_W = DIV_DEN_W + DIV_QUO_W;

    logic [DIV_NUM_W-1:0] r_rem [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] r_den [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] r_quo [DIV_QUO_W];
    logic                 r_ovf [DIV_QUO_W];

    logic [DIV_NUM_W-1:0] n_rem [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] n_quo [DIV_QUO_W];

    // Each stage tries the divisor shifted to its quotient bit.
    always_comb begin
        logic [DIV_NUM_W-1:0] p_rem;
        logic [DIV_DEN_W-1:0] p_den;
        logic [DIV_QUO_W-1:0] p_quo;
        logic [CMP_W-1:0]     sh;
        logic [CMP_W-1:0]     rem_x;
        int                   j;
        for (int k = 0; k < DIV_QUO_W; k++) begin
            if (k == 0) begin
                p_rem = i_num;
                p_den = i_den;
                p_quo = '0;
            end else begin
                p_rem = r_rem[k-1];
                p_den = r_den[k-1];
                p_quo = r_quo[k-1];
            end
            j     = DIV_QUO_W - 1 - k;
            sh    = CMP_W'(p_den) << j;
            rem_x = CMP_W'(p_rem);
            if (rem_x >= sh) begin
                n_rem[k] = DIV_NUM_W'(rem_x - sh);
                n_quo[k] = p_quo | (DIV_QUO_W'(1) << j);
            end else begin
                n_rem[k] = p_rem;
                n_quo[k] = p_quo;
            end
        end
    end

    // Stage registers; the overflow flag is decided on entry.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                if (k == 0) begin
                    r_den[k] <= i_den;
                    r_ovf[k] <= (i_num >> DIV_QUO_W) >= DIV_NUM_W'(i_den);
                end else begin
                    r_den[k] <= r_den[k-1];
                    r_ovf[k] <= r_ovf[k-1];
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_QUO_W-1];
    assign o_ovf = r_ovf[DIV_QUO_W-1];

endmodule

// ===== design/fio_isqrt.sv =====
// ============================================================================
// fio_isqrt
// Pipelined integer square root, one root bit per stage.
// ============================================================================
module fio_isqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [fio_pkg::SQ_IN_W-1:0]  i_x,
    output logic [fio_pkg::SQ_OUT_W-1:0] o_root
);
    import fio_pkg::*;

    localparam int WK_W = SQ_IN_W + 1;

    logic [WK_W-1:0] r_x [SQ_OUT_W];
    logic [WK_W-1:0] r_r [SQ_OUT_W];
    logic [WK_W-1:0] n_x [SQ_OUT_W];
    logic [WK_W-1:0] n_r [SQ_OUT_W];

    // Digit recurrence: b walks down the powers of four.
    always_comb begin
        logic [WK_W-1:0] p_x;
        logic [WK_W-1:0] p_r;
        logic [WK_W-1:0] b;
        int              j;
        for (int k = 0; k < SQ_OUT_W; k++) begin
            if (k == 0) begin
                p_x = WK_W'(i_x);
                p_r = '0;
            end else begin
                p_x = r_x[k-1];
                p_r = r_r[k-1];
            end
            j = SQ_OUT_W - 1 - k;
            b = WK_W'(1) << (2 * j);
            if (p_x >= p_r + b) begin
                n_x[k] = p_x - (p_r + b);
                n_r[k] = (p_r >> 1) + b;
            end else begin
                n_x[k] = p_x;
                n_r[k] = p_r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_OUT_W; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_root = r_r[SQ_OUT_W-1][SQ_OUT_W-1:0];

endmodule
